[src/port_scan_detector_defines.svh]
// Assertion macros for the port scan detector.
// Depends on nothing; users supply signals named clock and reset.
`ifndef PORT_SCAN_DETECTOR_DEFINES_SVH
`define PORT_SCAN_DETECTOR_DEFINES_SVH
`ifndef SYNTHESIS
`define PSD_ASSERT(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("port scan detector check failed");
`define PSD_ASSERT_NXT(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("port scan detector check failed");
`else
`define PSD_ASSERT(lbl, pre, post)
`define PSD_ASSERT_NXT(lbl, pre, post)
`endif
`endif

[src/psd_pkg.sv]
// Shared types and constants of the port scan detector.
// No dependencies.
package psd_pkg;
   localparam int DEF_SOURCE_ENTRIES = 64;
   localparam int DEF_PORT_SLOTS     = 32;
   localparam int LIMIT_W            = 6;
   localparam int WORD_W             = 32;
   localparam int CNT_W              = 9;   // holds up to 511 live slots

   localparam logic [LIMIT_W-1:0] DEF_LIMIT  = 6'd20;
   localparam logic [WORD_W-1:0]  DEF_WINDOW = 32'd60;

   localparam logic [1:0] PROTO_TCP = 2'd0;
   localparam logic [1:0] PROTO_UDP = 2'd1;

   typedef enum logic {
      CSR_LIMIT  = 1'b0,
      CSR_WINDOW = 1'b1
   } csr_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_LK_RD, ST_LK_CHK, ST_FR_RD, ST_FR_CHK, ST_FT_RD, ST_FT_AGE,
      ST_FT_CHK, ST_EX_RD, ST_EX_AGE, ST_EX_CHK, ST_FIN, ST_SKIP
   } state_type;

   typedef struct packed {
      logic accept;
      logic e_first;
      logic e_next;
      logic k_first;
      logic k_next;
      logic row_rd;
      logic slot_rd;
      logic age_ld;
      logic use_match;
      logic take;
      logic slot_chk;
      logic set_full;
      logic finish;
      logic skip;
   } cmd_type;

   typedef struct packed {
      logic proto_ok;
      logic lk_hit;
      logic row_zero;
      logic e_last;
      logic k_last;
      logic cur_busy;
      logic out_free;
   } status_type;
endpackage

[src/psd_ctrl.sv]
// Sequencer of the port scan detector: lookup, free search, slot pass, result.
// Depends on psd_pkg.
module psd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  psd_pkg::status_type  stat,
   output psd_pkg::cmd_type     cmd
);
   psd_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= psd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = (state_ff != psd_pkg::ST_IDLE);
      unique case (state_ff)
         psd_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.accept  = 1'b1;
               cmd.e_first = 1'b1;
               state_in    = stat.proto_ok ? psd_pkg::ST_LK_RD : psd_pkg::ST_SKIP;
            end
         end
         psd_pkg::ST_LK_RD: begin
            cmd.row_rd = 1'b1;
            state_in   = psd_pkg::ST_LK_CHK;
         end
         psd_pkg::ST_LK_CHK: begin
            if (stat.lk_hit) begin
               cmd.use_match = 1'b1;
               cmd.k_first   = 1'b1;
               state_in      = psd_pkg::ST_EX_RD;
            end else if (stat.e_last) begin
               cmd.e_first = 1'b1;
               state_in    = psd_pkg::ST_FR_RD;
            end else begin
               cmd.e_next = 1'b1;
               state_in   = psd_pkg::ST_LK_RD;
            end
         end
         psd_pkg::ST_FR_RD: begin
            cmd.row_rd = 1'b1;
            state_in   = psd_pkg::ST_FR_CHK;
         end
         psd_pkg::ST_FR_CHK: begin
            cmd.k_first = 1'b1;
            if (stat.row_zero) begin
               cmd.take = 1'b1;
               state_in = psd_pkg::ST_EX_RD;
            end else begin
               state_in = psd_pkg::ST_FT_RD;
            end
         end
         psd_pkg::ST_FT_RD: begin
            cmd.slot_rd = 1'b1;
            state_in    = psd_pkg::ST_FT_AGE;
         end
         psd_pkg::ST_FT_AGE: begin
            cmd.age_ld = 1'b1;
            state_in   = psd_pkg::ST_FT_CHK;
         end
         psd_pkg::ST_FT_CHK: begin
            if (stat.cur_busy) begin
               if (stat.e_last) begin
                  cmd.set_full = 1'b1;
                  state_in     = psd_pkg::ST_SKIP;
               end else begin
                  cmd.e_next = 1'b1;
                  state_in   = psd_pkg::ST_FR_RD;
               end
            end else if (stat.k_last) begin
               cmd.take    = 1'b1;
               cmd.k_first = 1'b1;
               state_in    = psd_pkg::ST_EX_RD;
            end else begin
               cmd.k_next = 1'b1;
               state_in   = psd_pkg::ST_FT_RD;
            end
         end
         psd_pkg::ST_EX_RD: begin
            cmd.slot_rd = 1'b1;
            state_in    = psd_pkg::ST_EX_AGE;
         end
         psd_pkg::ST_EX_AGE: begin
            cmd.age_ld = 1'b1;
            state_in   = psd_pkg::ST_EX_CHK;
         end
         psd_pkg::ST_EX_CHK: begin
            cmd.slot_chk = 1'b1;
            if (stat.k_last) begin
               state_in = psd_pkg::ST_FIN;
            end else begin
               cmd.k_next = 1'b1;
               state_in   = psd_pkg::ST_EX_RD;
            end
         end
         psd_pkg::ST_FIN: begin
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = psd_pkg::ST_IDLE;
            end
         end
         psd_pkg::ST_SKIP: begin
            if (stat.out_free) begin
               cmd.skip = 1'b1;
               state_in = psd_pkg::ST_IDLE;
            end
         end
         default: state_in = psd_pkg::ST_IDLE;
      endcase
   end
endmodule

[src/psd_datapath.sv]
// Datapath of the port scan detector: tables, slot pass logic, result register.
// Depends on psd_pkg.
module psd_datapath #(
   parameter int SOURCE_ENTRIES = psd_pkg::DEF_SOURCE_ENTRIES,
   parameter int PORT_SLOTS     = psd_pkg::DEF_PORT_SLOTS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  psd_pkg::cmd_type             cmd,
   output psd_pkg::status_type          stat,
   input  logic [1:0]                   req_protocol_code,
   input  logic [31:0]                  req_source_address,
   input  logic [15:0]                  req_destination_port,
   input  logic [31:0]                  req_arrival_time,
   input  logic                         csr_write_enable,
   input  logic                         csr_index,
   input  logic [31:0]                  csr_write_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_alert,
   output logic [31:0]                  rsp_alert_source,
   output logic [5:0]                   rsp_distinct_ports_seen,
   output logic                         rsp_table_full
);
   localparam int N   = SOURCE_ENTRIES;
   localparam int P   = PORT_SLOTS;
   localparam int EW  = (N > 1) ? $clog2(N) : 1;
   localparam int KW  = (P > 1) ? $clog2(P) : 1;
   localparam int SW  = (N * P > 1) ? $clog2(N * P) : 1;
   localparam int CW  = psd_pkg::CNT_W;

   // config
   logic [psd_pkg::LIMIT_W-1:0] limit_ff;
   logic [31:0]                 window_ff;

   // item
   logic [31:0] src_ff, now_ff;
   logic [15:0] dport_ff;
   logic        full_ff;

   // walk
   logic [EW-1:0] e_ff;
   logic [KW-1:0] k_ff;
   logic [SW-1:0] base_ff;
   logic [P-1:0]  live_ff;
   logic [31:0]   age_ff;

   // pass results
   logic          match_ff, free_ff;
   logic [KW-1:0] match_idx_ff, free_idx_ff, best_idx_ff;
   logic [31:0]   best_age_ff;
   logic [CW-1:0] cnt_ff;

   // tables
   logic [31:0]  addr_mem [N];
   logic [P-1:0] live_mem [N];
   logic [15:0]  port_mem [N*P];
   logic [31:0]  time_mem [N*P];
   logic [N-1:0] row_valid_ff;

   logic [31:0]  addr_q;
   logic [P-1:0] row_q;
   logic         row_vld_q;
   logic [15:0]  port_q;
   logic [31:0]  time_q;

   logic          rsp_valid_ff, rsp_alert_ff, rsp_full_ff;
   logic [31:0]   rsp_src_ff;
   logic [5:0]    rsp_cnt_ff;

   logic [P-1:0]  row;
   logic          expired, lv;
   logic [KW-1:0] hit_idx;
   logic [CW-1:0] cnt_new;
   logic          alert_new;
   logic [P-1:0]  live_new;
   logic [SW-1:0] rd_addr, wr_addr;
   logic          out_free;

   assign row      = row_vld_q ? row_q : '0;
   assign expired  = age_ff > window_ff;
   assign lv       = live_ff[k_ff] && !expired;
   assign hit_idx  = match_ff ? match_idx_ff : (free_ff ? free_idx_ff : best_idx_ff);
   assign cnt_new  = cnt_ff + CW'((!match_ff && free_ff) ? 1 : 0);
   assign alert_new = cnt_new >= CW'(limit_ff);
   assign live_new = live_ff | (P'(1) << hit_idx);
   assign rd_addr  = base_ff + SW'(k_ff);
   assign wr_addr  = base_ff + SW'(hit_idx);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign stat.proto_ok = (req_protocol_code == psd_pkg::PROTO_TCP) ||
                          (req_protocol_code == psd_pkg::PROTO_UDP);
   assign stat.lk_hit   = (addr_q == src_ff) && (row != '0);
   assign stat.row_zero = (row == '0);
   assign stat.e_last   = (e_ff == EW'(N - 1));
   assign stat.k_last   = (k_ff == KW'(P - 1));
   assign stat.cur_busy = row[k_ff] && !expired;
   assign stat.out_free = out_free;

   // control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= psd_pkg::DEF_LIMIT;
         window_ff    <= psd_pkg::DEF_WINDOW;
         rsp_valid_ff <= 1'b0;
         row_valid_ff <= '0;
      end else begin
         if (csr_write_enable) begin
            unique case (psd_pkg::csr_type'(csr_index))
               psd_pkg::CSR_LIMIT:  limit_ff  <= csr_write_data[psd_pkg::LIMIT_W-1:0];
               psd_pkg::CSR_WINDOW: window_ff <= csr_write_data;
               default: ;
            endcase
         end
         if (cmd.finish) begin
            row_valid_ff[e_ff] <= 1'b1;
         end
         if (cmd.finish || cmd.skip) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload and walk registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         src_ff   <= req_source_address;
         dport_ff <= req_destination_port;
         now_ff   <= req_arrival_time;
         full_ff  <= 1'b0;
      end
      if (cmd.set_full) begin
         full_ff <= 1'b1;
      end
      if (cmd.e_first) begin
         e_ff    <= '0;
         base_ff <= '0;
      end else if (cmd.e_next) begin
         e_ff    <= e_ff + EW'(1);
         base_ff <= base_ff + SW'(P);
      end
      if (cmd.k_first) begin
         k_ff     <= '0;
         match_ff <= 1'b0;
         free_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         if (cmd.k_next) begin
            k_ff <= k_ff + KW'(1);
         end
         if (cmd.slot_chk) begin
            if (lv) begin
               cnt_ff <= cnt_ff + CW'(1);
            end
            if (lv && (port_q == dport_ff) && !match_ff) begin
               match_ff     <= 1'b1;
               match_idx_ff <= k_ff;
            end
            if (!lv && !free_ff) begin
               free_ff     <= 1'b1;
               free_idx_ff <= k_ff;
            end
            if ((k_ff == '0) || (age_ff > best_age_ff)) begin
               best_age_ff <= age_ff;
               best_idx_ff <= k_ff;
            end
         end
      end
      if (cmd.age_ld) begin
         age_ff <= now_ff - time_q;
      end
      if (cmd.take) begin
         live_ff <= '0;
      end else if (cmd.use_match) begin
         live_ff <= row;
      end else if (cmd.slot_chk) begin
         live_ff[k_ff] <= lv;
      end
      if (cmd.row_rd) begin
         row_vld_q <= row_valid_ff[e_ff];
      end
      if (cmd.finish) begin
         rsp_alert_ff <= alert_new;
         rsp_src_ff   <= src_ff;
         rsp_cnt_ff   <= (cnt_new > CW'(63)) ? 6'd63 : cnt_new[5:0];
         rsp_full_ff  <= 1'b0;
      end else if (cmd.skip) begin
         rsp_alert_ff <= 1'b0;
         rsp_src_ff   <= src_ff;
         rsp_cnt_ff   <= 6'd0;
         rsp_full_ff  <= full_ff;
      end
   end

   // tables
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         addr_mem[e_ff] <= src_ff;
      end
      if (cmd.finish) begin
         live_mem[e_ff]    <= alert_new ? '0 : live_new;
         port_mem[wr_addr] <= dport_ff;
         time_mem[wr_addr] <= now_ff;
      end
      if (cmd.row_rd) begin
         addr_q <= addr_mem[e_ff];
         row_q  <= live_mem[e_ff];
      end
      if (cmd.slot_rd) begin
         port_q <= port_mem[rd_addr];
         time_q <= time_mem[rd_addr];
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_alert               = rsp_alert_ff;
   assign rsp_alert_source        = rsp_src_ff;
   assign rsp_distinct_ports_seen = rsp_cnt_ff;
   assign rsp_table_full          = rsp_full_ff;
endmodule

[src/port_scan_detector.sv]
// Top level of the port scan detector: sequencer plus datapath.
// Depends on psd_pkg, psd_ctrl, psd_datapath, port_scan_detector_defines.svh.
//
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall | protocol, source, port, time
//  rsp     | out       | rsp_valid/rsp_stall | alert, source, count, table_full
//  csr     | in        | csr_write_enable    | index, 32-bit data
//
// One packet at a time, taken in the idle state. Lookup reads and checks each
// entry in turn. A source already present then runs the slot pass, with read,
// age and check steps per slot, and loads the result. A new source first scans
// all entries, then scans again for a free entry, examining the slots of an entry
// with live hits; the slot pass follows. Non TCP/UDP packets skip to the result.
// Tables need no clearing pass; reset clears only the per-entry row valid bits.
// A stalled result holds; a new packet is taken meanwhile and waits at the end.
`include "port_scan_detector_defines.svh"
module port_scan_detector #(
   parameter int SOURCE_ENTRIES = psd_pkg::DEF_SOURCE_ENTRIES,
   parameter int PORT_SLOTS     = psd_pkg::DEF_PORT_SLOTS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_protocol_code,
   input  logic [31:0] req_source_address,
   input  logic [15:0] req_destination_port,
   input  logic [31:0] req_arrival_time,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_alert,
   output logic [31:0] rsp_alert_source,
   output logic [5:0]  rsp_distinct_ports_seen,
   output logic        rsp_table_full,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [31:0] csr_write_data
);
   psd_pkg::cmd_type    cmd;
   psd_pkg::status_type stat;

   // sequencer: one state per table or slot access step
   psd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // tables, shared age/compare unit, result register
   psd_datapath #(
      .SOURCE_ENTRIES (SOURCE_ENTRIES),
      .PORT_SLOTS     (PORT_SLOTS)
   ) u_dp (
      .clock                   (clock),
      .reset                   (reset),
      .cmd                     (cmd),
      .stat                    (stat),
      .req_protocol_code       (req_protocol_code),
      .req_source_address      (req_source_address),
      .req_destination_port    (req_destination_port),
      .req_arrival_time        (req_arrival_time),
      .csr_write_enable        (csr_write_enable),
      .csr_index               (csr_index),
      .csr_write_data          (csr_write_data),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_alert               (rsp_alert),
      .rsp_alert_source        (rsp_alert_source),
      .rsp_distinct_ports_seen (rsp_distinct_ports_seen),
      .rsp_table_full          (rsp_table_full)
   );

   // a full table never alerts
   `PSD_ASSERT(a_full_no_alert, rsp_valid && rsp_table_full, !rsp_alert)
   // an alert always counts at least the port just recorded
   `PSD_ASSERT(a_alert_count, rsp_valid && rsp_alert, rsp_distinct_ports_seen != 6'd0)
   // a packet taken keeps the input stalled while it is worked on
   `PSD_ASSERT_NXT(a_busy_after_take, req_valid && !req_stall, req_stall)
endmodule
